// ===== hdl/ptt_pkg.sv =====
// Shared types, widths and codes for the translation table unit.
// Used by ptt_cam, the top level and the port checker; depends on nothing.
package ptt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int KIND_W  = 2;
    localparam int PROC_W  = 22;
    localparam int VPAGE_W = 52;
    localparam int PPAGE_W = 24;
    localparam int STAT_W  = 2;

    // Operation codes carried by the kind field.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PURGE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd3;

    // One operation presented to the key store; en commits its update.
    typedef struct packed {
        logic               en;
        logic [KIND_W-1:0]  kind;
        logic [PROC_W-1:0]  proc_id;
        logic [VPAGE_W-1:0] virt_page;
    } cam_req_t;

    // Outcome of the parallel key compare against the current table.
    typedef struct packed {
        logic             match_any;
        logic [IDX_W-1:0] match_idx;
        logic             free_any;
        logic [IDX_W-1:0] free_idx;
        logic             purge_any;
    } cam_rsp_t;

endpackage

// ===== hdl/pid_vpn_translation_table_unit.sv =====
// Translation table keyed by process id and virtual page, top level.
// Items pass the input register, then the result register; one item per cycle sustained
// while out_stall is low, set by the parallel key compare and one page memory read port.
// Reset (rst_n, asynchronous, active low) empties the table at once and drops any item
// in flight; page memory and key slots keep no reset and are read only behind valid bits.
// Depends on ptt_pkg and ptt_cam.
module pid_vpn_translation_table_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ptt_pkg::KIND_W-1:0]   kind,
    input  logic [ptt_pkg::PROC_W-1:0]   proc_id,
    input  logic [ptt_pkg::VPAGE_W-1:0]  virt_page,
    input  logic [ptt_pkg::PPAGE_W-1:0]  phys_page,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ptt_pkg::STAT_W-1:0]   status,
    output logic                         hit,
    output logic [ptt_pkg::PPAGE_W-1:0]  mapped_page
);
    import ptt_pkg::*;

    // Input register: one item waiting to be executed against the table.
    logic               s1_valid_reg;
    logic [KIND_W-1:0]  s1_kind_reg;
    logic [PROC_W-1:0]  s1_proc_reg;
    logic [VPAGE_W-1:0] s1_vpage_reg;
    logic [PPAGE_W-1:0] s1_ppage_reg;

    // Result register. The mapped page comes from the page memory's registered
    // read port, which only updates when a lookup executes, so it holds while stalled.
    logic               out_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic               hit_reg;
    logic [PPAGE_W-1:0] rdata_reg;
    logic [STAT_W-1:0]  status_next;

    logic [PPAGE_W-1:0] page_mem [ENTRIES];

    logic     in_accept;
    logic     s1_adv;
    logic     do_insert;
    cam_req_t cam_req;
    cam_rsp_t cam_rsp;

    // The waiting item executes as soon as the result register is free or emptying.
    // Its table update and its result are committed at the same edge, so the next
    // item always sees the table as this one leaves it.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    assign cam_req.en        = s1_adv;
    assign cam_req.kind      = s1_kind_reg;
    assign cam_req.proc_id   = s1_proc_reg;
    assign cam_req.virt_page = s1_vpage_reg;

    ptt_cam u_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cam_req),
        .rsp   (cam_rsp)
    );

    assign do_insert = s1_adv && (s1_kind_reg == KIND_INSERT)
                       && !cam_rsp.match_any && cam_rsp.free_any;

    // Status for each operation. An insert of a present key keeps the old mapping.
    always_comb
    begin
        case (s1_kind_reg)
            KIND_INSERT:
            begin
                if (cam_rsp.match_any)
                begin
                    status_next = ST_DUP;
                end
                else if (cam_rsp.free_any)
                begin
                    status_next = ST_OK;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            KIND_PURGE:  status_next = cam_rsp.purge_any ? ST_OK : ST_MISS;
            default:     status_next = cam_rsp.match_any ? ST_OK : ST_MISS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept || (s1_valid_reg && !s1_adv);
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg  <= kind;
            s1_proc_reg  <= proc_id;
            s1_vpage_reg <= virt_page;
            s1_ppage_reg <= phys_page;
        end
        if (s1_adv)
        begin
            status_reg <= status_next;
            hit_reg    <= (s1_kind_reg == KIND_LOOKUP) && cam_rsp.match_any;
        end
    end

    // Page memory: written by a successful insert, read by a lookup.
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            page_mem[cam_rsp.free_idx] <= s1_ppage_reg;
        end
        if (s1_adv && (s1_kind_reg == KIND_LOOKUP))
        begin
            rdata_reg <= page_mem[cam_rsp.match_idx];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign hit         = hit_reg;
    assign mapped_page = hit_reg ? rdata_reg : '0;

endmodule

// ===== hdl/ptt_cam.sv =====
// Key store of the translation table: valid bits and key slots with a parallel compare.
// Depends on ptt_pkg.
module ptt_cam (
    input  logic              clk,
    input  logic              rst_n,
    input  ptt_pkg::cam_req_t req,
    output ptt_pkg::cam_rsp_t rsp
);
    import ptt_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [PROC_W-1:0]  proc_reg  [ENTRIES];
    logic [VPAGE_W-1:0] vpage_reg [ENTRIES];

    logic [ENTRIES-1:0] proc_vec;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_first;
    logic [IDX_W-1:0]   match_idx;
    logic [IDX_W-1:0]   free_idx;
    logic               do_insert;

    // Every slot compares in parallel; keys are unique, so at most one match.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            proc_vec[i]  = valid_reg[i] && (proc_reg[i] == req.proc_id);
            match_vec[i] = proc_vec[i] && (vpage_reg[i] == req.virt_page);
        end
    end

    // Lowest free slot isolated as a one-hot word.
    assign free_vec   = ~valid_reg;
    assign free_first = free_vec & (~free_vec + ENTRIES'(1));

    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                match_idx = match_idx | IDX_W'(i);
            end
            if (free_first[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    assign rsp.match_any = |match_vec;
    assign rsp.match_idx = match_idx;
    assign rsp.free_any  = |free_vec;
    assign rsp.free_idx  = free_idx;
    assign rsp.purge_any = |proc_vec;

    assign do_insert = req.en && (req.kind == KIND_INSERT) && !rsp.match_any && rsp.free_any;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.en)
        begin
            case (req.kind)
                KIND_INSERT:
                begin
                    if (do_insert)
                    begin
                        valid_next = valid_reg | free_first;
                    end
                end
                KIND_DELETE: valid_next = valid_reg & ~match_vec;
                KIND_PURGE:  valid_next = valid_reg & ~proc_vec;
                default:     valid_next = valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            proc_reg[free_idx]  <= req.proc_id;
            vpage_reg[free_idx] <= req.virt_page;
        end
    end

endmodule

// ===== hdl/ptt_checker.sv =====
// Port-level checker for the translation table unit, with its bind statement.
// Depends on ptt_pkg and pid_vpn_translation_table_unit.
module ptt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [ptt_pkg::STAT_W-1:0]   status,
    input logic                         hit,
    input logic [ptt_pkg::PPAGE_W-1:0]  mapped_page
);
    import ptt_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(hit)
                                   && $stable(mapped_page))
        else $error("stalled result changed");

    // A hit is always reported with an ok status.
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> status == ST_OK)
        else $error("hit without ok status");

    // Without a hit the mapped page reads as zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> mapped_page == '0)
        else $error("mapped page nonzero without hit");

    // A result that appears on an idle output was accepted earlier and passed the input register without waiting.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without an item two cycles before");

endmodule

bind pid_vpn_translation_table_unit ptt_checker u_ptt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .hit         (hit),
    .mapped_page (mapped_page)
);
